@@ sv/single_wire_sensor_reader_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_READER_UNIT_MACROS_SVH
`define SINGLE_WIRE_SENSOR_READER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SWSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/swsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader package
// Transaction payloads, configuration registers, phase and status codes.
// ----------------------------------------------------------------------------
package swsr_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_START_LOW_US       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_US         = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RESPONSE_SAMPLE_US = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RESPONSE_CHECK_US  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BIT_SAMPLE_US      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BYTE_COUNT         = 3'd5;

  localparam logic [15:0] RST_START_LOW_US       = 16'd18000;
  localparam logic [15:0] RST_RELEASE_US         = 16'd20;
  localparam logic [15:0] RST_RESPONSE_SAMPLE_US = 16'd40;
  localparam logic [15:0] RST_RESPONSE_CHECK_US  = 16'd80;
  localparam logic [15:0] RST_BIT_SAMPLE_US      = 16'd40;
  localparam logic [3:0]  RST_BYTE_COUNT         = 4'd5;

  localparam logic [3:0] MIN_BYTES = 4'd1;
  localparam logic [3:0] MAX_BYTES = 4'd8;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_NO_RESP  = 2'd2;
  localparam logic [1:0] ST_BAD_RESP = 2'd3;

  typedef enum logic [9:0] {
    PH_IDLE       = 10'b00_0000_0001,
    PH_START_LOW  = 10'b00_0000_0010,
    PH_RELEASE    = 10'b00_0000_0100,
    PH_RESP_WAIT  = 10'b00_0000_1000,
    PH_RESP_CHECK = 10'b00_0001_0000,
    PH_RESP_END   = 10'b00_0010_0000,
    PH_BIT_RISE   = 10'b00_0100_0000,
    PH_BIT_DELAY  = 10'b00_1000_0000,
    PH_BIT_FALL   = 10'b01_0000_0000,
    PH_FINAL_FALL = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic start_request;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       drive_high;
    logic [1:0] status;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic [15:0] start_low_us;
    logic [15:0] release_us;
    logic [15:0] response_sample_us;
    logic [15:0] response_check_us;
    logic [15:0] bit_sample_us;
    logic [3:0]  byte_count;
  } cfg_regs_t;

  // Sequencer state apart from the microsecond counter.
  typedef struct packed {
    phase_t     phase;
    logic [2:0] bit_index;
    logic [2:0] byte_index;
    logic [7:0] shift_byte;
  } seq_state_t;

endpackage

@@ sv/swsr_in_if.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader input channel
// One microsecond tick per transaction: start request and line sample.
// ----------------------------------------------------------------------------
interface swsr_in_if;
  logic               valid;
  logic               ready;
  swsr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/swsr_out_if.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader result channel
// One result transaction per input tick: line drive, status and bytes.
// ----------------------------------------------------------------------------
interface swsr_out_if;
  logic                valid;
  logic                ready;
  swsr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/single_wire_sensor_reader_unit.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader
// Host side of a single-bus temperature/humidity sensor, one tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one in_ch transaction per microsecond tick, carrying start_request
//   and the sampled line level. Every accepted tick yields exactly one out_ch
//   transaction with the line drive for that tick, a response status on the
//   tick the response is judged, and decoded bytes (MSB first) with a
//   last_byte mark on the final one.
//   The result of a tick sits in the output register on the cycle after it
//   is accepted. Throughput is one tick per cycle while out_ch does not stall,
//   set by the single-pass tick logic between the sequencer state register
//   and the output register.
//   When out_ch stalls, the output register holds its transaction and in_ch
//   ready drops until it is taken; ready returns in the same cycle the
//   receiver takes the held result.
//   Reset puts the sequencer in idle, clears the counters and loads the
//   default timings (18 ms start low, 20/40/80/40 us, five bytes).
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata
//   while idle; indexes past the register list are ignored.
//   A start request aborts any transfer and drives the line low that tick.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  swsr_in_if.sink                              in_ch,
  swsr_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [swsr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [swsr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import swsr_pkg::*;

  `include "single_wire_sensor_reader_unit_macros.svh"

  cfg_regs_t             cfg_r;
  seq_state_t            seq_r, seq_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  out_item_t             res_r, res_nxt;
  logic                  res_valid_r;
  logic                  in_fire;

  // Take a new tick whenever the output register is empty or being drained.
  assign in_ch.ready  = !res_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = res_valid_r;
  assign out_ch.data  = res_r;

  // Configuration registers; writes must arrive only while idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_us       <= RST_START_LOW_US;
      cfg_r.release_us         <= RST_RELEASE_US;
      cfg_r.response_sample_us <= RST_RESPONSE_SAMPLE_US;
      cfg_r.response_check_us  <= RST_RESPONSE_CHECK_US;
      cfg_r.bit_sample_us      <= RST_BIT_SAMPLE_US;
      cfg_r.byte_count         <= RST_BYTE_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_LOW_US:       cfg_r.start_low_us       <= cfg_wdata;
        CFG_RELEASE_US:         cfg_r.release_us         <= cfg_wdata;
        CFG_RESPONSE_SAMPLE_US: cfg_r.response_sample_us <= cfg_wdata;
        CFG_RESPONSE_CHECK_US:  cfg_r.response_check_us  <= cfg_wdata;
        CFG_BIT_SAMPLE_US:      cfg_r.bit_sample_us      <= cfg_wdata;
        CFG_BYTE_COUNT:         cfg_r.byte_count         <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  swsr_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cur_st  (seq_r),
    .cur_cnt (cnt_r),
    .cfg     (cfg_r),
    .item    (in_ch.data),
    .nxt_st  (seq_nxt),
    .nxt_cnt (cnt_nxt),
    .res     (res_nxt)
  );

  // Advance the sequencer only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.phase      <= PH_IDLE;
      seq_r.bit_index  <= '0;
      seq_r.byte_index <= '0;
      seq_r.shift_byte <= '0;
      cnt_r            <= '0;
    end else if (in_fire) begin
      seq_r <= seq_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Output register: load on accept, drop valid once the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_fire) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  `SWSR_ASSERT_NEXT(a_start_drives_low, in_fire && in_ch.data.start_request,
    out_ch.valid && out_ch.data.drive_low && out_ch.data.busy_res,
    "start tick did not drive the line low")
  `SWSR_ASSERT_IMPL(a_ready_when_empty, !res_valid_r, in_ch.ready,
    "input stalled while output register empty")
  `SWSR_ASSERT_IMPL(a_no_accept_on_stall, out_ch.valid && !out_ch.ready, !in_ch.ready,
    "tick accepted while result stalled")
  `SWSR_ASSERT_NEXT(a_idle_no_drive, !in_fire && seq_r.phase == PH_IDLE,
    seq_r.phase == PH_IDLE,
    "sequencer left idle without an accepted tick")

endmodule

@@ sv/swsr_step.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader tick logic
// Next sequencer state and result for one microsecond tick.
// ----------------------------------------------------------------------------
module swsr_step #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  swsr_pkg::seq_state_t    cur_st,
  input  logic [COUNT_BITS-1:0]   cur_cnt,
  input  swsr_pkg::cfg_regs_t     cfg,
  input  swsr_pkg::in_item_t      item,
  output swsr_pkg::seq_state_t    nxt_st,
  output logic [COUNT_BITS-1:0]   nxt_cnt,
  output swsr_pkg::out_item_t     res
);
  import swsr_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Clamp a delay register to what the counter can reach.
  function automatic logic [COUNT_BITS-1:0] sat_delay(input logic [15:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve > CW'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return COUNT_BITS'(ve);
  endfunction

  logic [COUNT_BITS-1:0] d_start, d_release, d_resp_sample, d_resp_check, d_bit;
  logic [COUNT_BITS-1:0] cnt_base, cnt_inc;
  seq_state_t            base;
  logic [3:0]            eff_bytes;
  logic [7:0]            shifted;
  logic                  last_hit;

  assign d_start       = sat_delay(cfg.start_low_us);
  assign d_release     = sat_delay(cfg.release_us);
  assign d_resp_sample = sat_delay(cfg.response_sample_us);
  assign d_resp_check  = sat_delay(cfg.response_check_us);
  assign d_bit         = sat_delay(cfg.bit_sample_us);

  assign eff_bytes = (cfg.byte_count < MIN_BYTES) ? MIN_BYTES :
                     (cfg.byte_count > MAX_BYTES) ? MAX_BYTES : cfg.byte_count;

  // A start request restarts the sequence on this very tick.
  always_comb begin
    base     = cur_st;
    cnt_base = cur_cnt;
    if (item.start_request) begin
      base.phase      = PH_START_LOW;
      base.bit_index  = '0;
      base.byte_index = '0;
      base.shift_byte = '0;
      cnt_base        = '0;
    end
  end

  assign cnt_inc  = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
  assign shifted  = {base.shift_byte[6:0], item.line_level};
  assign last_hit = ({1'b0, base.byte_index} + 4'd1) >= eff_bytes;

  always_comb begin
    nxt_st       = base;
    nxt_cnt      = cnt_base;
    res          = '0;
    res.busy_res = (base.phase != PH_IDLE);
    case (base.phase)
      PH_IDLE: begin
      end
      PH_START_LOW: begin
        res.drive_low = 1'b1;
        nxt_cnt       = cnt_inc;
        if (cnt_inc >= d_start) begin
          nxt_st.phase = PH_RELEASE;
          nxt_cnt      = '0;
        end
      end
      PH_RELEASE: begin
        res.drive_high = 1'b1;
        nxt_cnt        = cnt_inc;
        if (cnt_inc >= d_release) begin
          nxt_st.phase = PH_RESP_WAIT;
          nxt_cnt      = '0;
        end
      end
      PH_RESP_WAIT: begin
        nxt_cnt = cnt_inc;
        if (cnt_inc >= d_resp_sample) begin
          nxt_cnt = '0;
          if (!item.line_level) begin
            nxt_st.phase = PH_RESP_CHECK;
          end else begin
            res.status   = ST_NO_RESP;
            nxt_st.phase = PH_IDLE;
          end
        end
      end
      PH_RESP_CHECK: begin
        nxt_cnt = cnt_inc;
        if (cnt_inc >= d_resp_check) begin
          nxt_cnt = '0;
          if (item.line_level) begin
            res.status   = ST_OK;
            nxt_st.phase = PH_RESP_END;
          end else begin
            res.status   = ST_BAD_RESP;
            nxt_st.phase = PH_IDLE;
          end
        end
      end
      PH_RESP_END: begin
        if (!item.line_level) begin
          nxt_st.phase = PH_BIT_RISE;
          nxt_cnt      = '0;
        end
      end
      PH_BIT_RISE: begin
        if (item.line_level) begin
          nxt_st.phase = PH_BIT_DELAY;
          nxt_cnt      = '0;
        end
      end
      PH_BIT_DELAY: begin
        nxt_cnt = cnt_inc;
        if (cnt_inc >= d_bit) begin
          nxt_cnt           = '0;
          nxt_st.shift_byte = shifted;
          nxt_st.phase      = PH_BIT_FALL;
          if (base.bit_index == 3'd7) begin
            nxt_st.bit_index = '0;
            res.byte_valid   = 1'b1;
            res.byte_value   = shifted;
            if (last_hit) begin
              res.last_byte = 1'b1;
              nxt_st.phase  = PH_FINAL_FALL;
            end else begin
              nxt_st.byte_index = base.byte_index + 3'd1;
            end
          end else begin
            nxt_st.bit_index = base.bit_index + 3'd1;
          end
        end
      end
      PH_BIT_FALL: begin
        if (!item.line_level) begin
          nxt_st.phase = PH_BIT_RISE;
          nxt_cnt      = '0;
        end
      end
      PH_FINAL_FALL: begin
        if (!item.line_level) begin
          nxt_st.phase = PH_IDLE;
          nxt_cnt      = '0;
        end
      end
      default: begin
        nxt_st.phase = PH_IDLE;
        nxt_cnt      = '0;
      end
    endcase
  end

endmodule

@@ dv/single_wire_sensor_reader_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader testbench
// Feeds microsecond ticks shaped by a behavioral sensor (good reply, silent,
// broken or stuck line) and checks every reply against a cycle-true mirror.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_unit_tb;
  import swsr_pkg::*;

  localparam int CNT_WIDTH        = 16;
  localparam int CNT_MAX          = (1 << CNT_WIDTH) - 1;
  localparam int PHASES           = 13;
  localparam int PHASE_TICKS      = 90;
  localparam int WIDE_PHASE_TICKS = 250;
  localparam int LONG_HOLD        = 200;
  localparam int HOLD_AFTER       = 500;
  localparam int DRAIN_TAIL       = 8;
  localparam int REPORT_LIMIT     = 10;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [15:0]             DELAY_MAX    = 16'hFFFF;

  // How the simulated sensor answers one transfer.
  typedef enum int {
    REPLY_GOOD,
    REPLY_SILENT,
    REPLY_BROKEN,
    REPLY_STUCK
  } reply_mode_t;

  // --------------------------------------------------------------------------
  // Mirror of the sequencer: predicts one reply per accepted tick and checks
  // replies in order.
  // --------------------------------------------------------------------------
  class sensor_reader_mirror;
    cfg_regs_t  regs;
    phase_t     phase;
    int         us_count;
    logic [2:0] bit_idx;
    logic [2:0] byte_idx;
    logic [7:0] shift_byte;
    out_item_t  expected_replies[$];
    int         replies;
    int         mismatches;
    int         ok_count;
    int         silent_count;
    int         bad_count;
    int         bytes_seen;
    int         reads_done;

    function new();
      regs.start_low_us       = RST_START_LOW_US;
      regs.release_us         = RST_RELEASE_US;
      regs.response_sample_us = RST_RESPONSE_SAMPLE_US;
      regs.response_check_us  = RST_RESPONSE_CHECK_US;
      regs.bit_sample_us      = RST_BIT_SAMPLE_US;
      regs.byte_count         = RST_BYTE_COUNT;
      phase      = PH_IDLE;
      us_count   = 0;
      bit_idx    = '0;
      byte_idx   = '0;
      shift_byte = '0;
      replies    = 0;
      mismatches = 0;
      ok_count   = 0;
      silent_count = 0;
      bad_count  = 0;
      bytes_seen = 0;
      reads_done = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        CFG_START_LOW_US:       regs.start_low_us = v;
        CFG_RELEASE_US:         regs.release_us = v;
        CFG_RESPONSE_SAMPLE_US: regs.response_sample_us = v;
        CFG_RESPONSE_CHECK_US:  regs.response_check_us = v;
        CFG_BIT_SAMPLE_US:      regs.bit_sample_us = v;
        CFG_BYTE_COUNT:         regs.byte_count = v[3:0];
        default: ;
      endcase
    endfunction

    function void enter(phase_t p);
      phase    = p;
      us_count = 0;
    endfunction

    function void count_us();
      if (us_count < CNT_MAX) us_count++;
    endfunction

    // Clip a delay to what the counter can reach.
    function int limit_of(logic [15:0] d);
      return (int'(d) > CNT_MAX) ? CNT_MAX : int'(d);
    endfunction

    function out_item_t advance(in_item_t t);
      out_item_t r;
      int        n;
      r = '0;
      // A start wins over everything, even mid-transfer.
      if (t.start_request) begin
        enter(PH_START_LOW);
        bit_idx    = '0;
        byte_idx   = '0;
        shift_byte = '0;
      end
      r.busy_res = (phase != PH_IDLE);
      case (phase)
        PH_IDLE: ;
        PH_START_LOW: begin
          r.drive_low = 1'b1;
          count_us();
          if (us_count >= limit_of(regs.start_low_us)) enter(PH_RELEASE);
        end
        PH_RELEASE: begin
          r.drive_high = 1'b1;
          count_us();
          if (us_count >= limit_of(regs.release_us)) enter(PH_RESP_WAIT);
        end
        PH_RESP_WAIT: begin
          count_us();
          if (us_count >= limit_of(regs.response_sample_us)) begin
            if (!t.line_level) begin
              enter(PH_RESP_CHECK);
            end else begin
              r.status = ST_NO_RESP;
              enter(PH_IDLE);
            end
          end
        end
        PH_RESP_CHECK: begin
          count_us();
          if (us_count >= limit_of(regs.response_check_us)) begin
            if (t.line_level) begin
              r.status = ST_OK;
              enter(PH_RESP_END);
            end else begin
              r.status = ST_BAD_RESP;
              enter(PH_IDLE);
            end
          end
        end
        PH_RESP_END: begin
          if (!t.line_level) enter(PH_BIT_RISE);
        end
        PH_BIT_RISE: begin
          if (t.line_level) enter(PH_BIT_DELAY);
        end
        PH_BIT_DELAY: begin
          count_us();
          if (us_count >= limit_of(regs.bit_sample_us)) begin
            shift_byte = {shift_byte[6:0], t.line_level};
            if (bit_idx == 3'd7) begin
              bit_idx      = '0;
              r.byte_valid = 1'b1;
              r.byte_value = shift_byte;
              n = int'(regs.byte_count);
              if (n < int'(MIN_BYTES)) n = int'(MIN_BYTES);
              if (n > int'(MAX_BYTES)) n = int'(MAX_BYTES);
              if (int'(byte_idx) + 1 >= n) begin
                r.last_byte = 1'b1;
                enter(PH_FINAL_FALL);
              end else begin
                byte_idx = byte_idx + 3'd1;
                enter(PH_BIT_FALL);
              end
            end else begin
              bit_idx = bit_idx + 3'd1;
              enter(PH_BIT_FALL);
            end
          end
        end
        PH_BIT_FALL: begin
          if (!t.line_level) enter(PH_BIT_RISE);
        end
        PH_FINAL_FALL: begin
          if (!t.line_level) enter(PH_IDLE);
        end
        default: enter(PH_IDLE);
      endcase
      return r;
    endfunction

    function void note_tick(in_item_t t);
      expected_replies.push_back(advance(t));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      bit        wrong;
      replies++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("reply %0d arrived with no tick outstanding", replies);
        return;
      end
      want  = expected_replies.pop_front();
      wrong = (got.drive_low  !== want.drive_low)  || (got.drive_high !== want.drive_high) ||
              (got.status     !== want.status)     || (got.byte_valid !== want.byte_valid) ||
              (got.byte_value !== want.byte_value) || (got.last_byte  !== want.last_byte)  ||
              (got.busy_res   !== want.busy_res);
      if (wrong) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("reply %0d: expected low=%b high=%b st=%0d bv=%b byte=%h last=%b busy=%b",
                   replies, want.drive_low, want.drive_high, want.status, want.byte_valid,
                   want.byte_value, want.last_byte, want.busy_res,
                   "\n           got      low=%b high=%b st=%0d bv=%b byte=%h last=%b busy=%b",
                   got.drive_low, got.drive_high, got.status, got.byte_valid,
                   got.byte_value, got.last_byte, got.busy_res);
      end
      case (want.status)
        ST_OK:       ok_count++;
        ST_NO_RESP:  silent_count++;
        ST_BAD_RESP: bad_count++;
        default: ;
      endcase
      if (want.byte_valid) bytes_seen++;
      if (want.last_byte) reads_done++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, ports and the block itself
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  swsr_in_if  in_ch ();
  swsr_out_if out_ch ();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  single_wire_sensor_reader_unit #(
    .COUNT_BITS (CNT_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sensor_reader_mirror mirror;

  // Sensor and traffic state shared by the stimulus tasks.
  reply_mode_t reply_mode;
  logic        stuck_level;
  logic        bit_level;
  int          xfer_ticks;
  int          xfer_budget;
  bit          no_idle;
  int          ticks_sent;
  int          transfers_started;

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Mostly short delays so transfers finish; now and then zero or the maximum.
  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 75) return 16'($urandom_range(1, 4));
    if (r < 92) return 16'($urandom_range(5, 40));
    if (r < 96) return DELAY_MAX;
    return 16'($urandom_range(41, 65534));
  endfunction

  function automatic reply_mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return REPLY_GOOD;
    if (r < 80) return REPLY_SILENT;
    if (r < 90) return REPLY_BROKEN;
    return REPLY_STUCK;
  endfunction

  // Line level the sensor would present on the next tick, given where the
  // sequencer is right now.
  function automatic logic sensor_level();
    int r;
    r = $urandom_range(0, 7);
    case (mirror.phase)
      PH_IDLE:       return (r != 0);
      PH_START_LOW:  return (r == 0);
      PH_RELEASE:    return (r != 0);
      PH_RESP_WAIT:  return (reply_mode == REPLY_SILENT);
      PH_RESP_CHECK: return (reply_mode != REPLY_BROKEN);
      PH_RESP_END: begin
        if (reply_mode == REPLY_STUCK) return stuck_level;
        return (r < 5);
      end
      PH_BIT_RISE: begin
        if (reply_mode == REPLY_STUCK) return stuck_level;
        // Pick the data bit at the rising edge and hold it through the sample.
        if (r < 3) begin
          bit_level = 1'($urandom_range(0, 1));
          return 1'b1;
        end
        return 1'b0;
      end
      PH_BIT_DELAY: begin
        if (reply_mode == REPLY_STUCK) return stuck_level;
        return bit_level;
      end
      default: begin
        if (reply_mode == REPLY_STUCK) return stuck_level;
        return (r < 3);
      end
    endcase
  endfunction

  // Offer one tick and hold it until the block takes it. Lower valid only
  // when a gap follows, so a streaming valid never toggles within a step.
  task automatic send_tick(input logic req, input logic level);
    in_item_t t;
    int       gap;
    t.start_request = req;
    t.line_level    = level;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    do @(posedge clk); while (!in_ch.ready);
    mirror.note_tick(t);
    ticks_sent++;
  endtask

  task automatic start_transfer(input reply_mode_t m);
    reply_mode  = m;
    xfer_ticks  = 0;
    xfer_budget = (m == REPLY_STUCK) ? $urandom_range(20, 80) : $urandom_range(300, 600);
    stuck_level = 1'($urandom_range(0, 1));
    transfers_started++;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
  endtask

  task automatic follow(input int n);
    repeat (n) send_tick(1'b0, sensor_level());
  endtask

  task automatic follow_to_idle();
    while (mirror.phase != PH_IDLE) send_tick(1'b0, sensor_level());
  endtask

  // One tick of free-running traffic: start from idle now and then, abort a
  // transfer that has run past its budget or at random, else act as the sensor.
  task automatic sensor_tick();
    logic req;
    req = 1'b0;
    if (mirror.phase == PH_IDLE) begin
      req = ($urandom_range(0, 3) == 0);
    end else begin
      xfer_ticks++;
      req = (xfer_ticks >= xfer_budget) || ($urandom_range(0, 299) == 0);
    end
    if (req) start_transfer(pick_mode());
    else send_tick(1'b0, sensor_level());
  endtask

  task automatic wait_drained();
    while (mirror.expected_replies.size() != 0) @(posedge clk);
  endtask

  // Write every register, plus the two unused indexes, once nothing is in
  // flight. Keep write enable high across the burst.
  task automatic load_cfg(input cfg_regs_t c);
    logic [CFG_IDX_BITS-1:0]  idx [8];
    logic [CFG_DATA_BITS-1:0] val [8];
    logic [11:0]              noise;
    in_ch.valid <= 1'b0;
    wait_drained();
    noise  = 12'($urandom);
    idx    = '{CFG_START_LOW_US, CFG_RELEASE_US, CFG_RESPONSE_SAMPLE_US,
               CFG_RESPONSE_CHECK_US, CFG_BIT_SAMPLE_US, CFG_BYTE_COUNT,
               CFG_SPARE_LO, CFG_SPARE_HI};
    val[0] = c.start_low_us;
    val[1] = c.release_us;
    val[2] = c.response_sample_us;
    val[3] = c.response_check_us;
    val[4] = c.bit_sample_us;
    val[5] = {noise, c.byte_count};
    val[6] = CFG_DATA_BITS'($urandom);
    val[7] = CFG_DATA_BITS'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      mirror.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every accepted reply, stall at random, and once hold
  // off long enough that the block fills and drops its input ready.
  // --------------------------------------------------------------------------
  initial begin : reply_sink
    int stall_left;
    bit held_once;
    stall_left   = 0;
    held_once    = 1'b0;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) mirror.check_reply(out_ch.data);
      if (!held_once && mirror.replies >= HOLD_AFTER) begin
        held_once  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: a short directed opening, then phases of free-running traffic,
  // each under its own timing setting.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_regs_t timing;
    int        ticks_target;
    mirror            = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.data        = '0;
    reply_mode        = REPLY_GOOD;
    stuck_level       = 1'b0;
    bit_level         = 1'b0;
    xfer_ticks        = 0;
    xfer_budget       = 0;
    no_idle           = 1'b0;
    ticks_sent        = 0;
    transfers_started = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start under reset timings; the line must be pulled low at once.
    start_transfer(REPLY_SILENT);
    follow(2);
    // Shrink every delay to zero while still in the start pulse; zero acts
    // as one tick and byte count zero acts as one byte.
    timing = '0;
    load_cfg(timing);
    // Sensor stays high: no response.
    follow_to_idle();
    // Low reply but no high reply: bad response.
    start_transfer(REPLY_BROKEN);
    follow_to_idle();
    // Abort a transfer in the response check with a fresh start.
    start_transfer(REPLY_GOOD);
    follow(2);
    start_transfer(REPLY_BROKEN);
    follow_to_idle();
    // Idle ticks with both line levels.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p % 4 == 3);
      case (p)
        // Keep the all-zero timing from the opening.
        0: ;
        1: begin
          timing.start_low_us       = DELAY_MAX;
          timing.release_us         = DELAY_MAX;
          timing.response_sample_us = DELAY_MAX;
          timing.response_check_us  = DELAY_MAX;
          timing.bit_sample_us      = DELAY_MAX;
          timing.byte_count         = 4'hF;
        end
        // Fast timing with an out-of-range byte count: reads run eight bytes.
        2: begin
          timing            = '0;
          timing.byte_count = 4'hF;
        end
        default: begin
          timing.start_low_us       = pick_delay();
          timing.release_us         = pick_delay();
          timing.response_sample_us = pick_delay();
          timing.response_check_us  = pick_delay();
          timing.bit_sample_us      = pick_delay();
          timing.byte_count         = ($urandom_range(0, 99) < 70) ?
                                      4'($urandom_range(1, 3)) :
                                      4'($urandom_range(0, 15));
        end
      endcase
      if (p > 0) load_cfg(timing);
      ticks_target = (p == 2) ? WIDE_PHASE_TICKS : PHASE_TICKS;
      repeat (ticks_target) sensor_tick();
    end

    // Drain, then give the output register time to show any stray reply.
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("run: %0d ticks, %0d transfers started, %0d timing settings, %0d replies",
             ticks_sent, transfers_started, PHASES + 1, mirror.replies);
    $display("run: %0d ok / %0d no response / %0d bad response, %0d bytes, %0d full reads",
             mirror.ok_count, mirror.silent_count, mirror.bad_count,
             mirror.bytes_seen, mirror.reads_done);
    if (mirror.mismatches == 0 && mirror.expected_replies.size() == 0) begin
      $display("[single_wire_sensor_reader_unit] OK");
    end else begin
      $display("mismatches: %0d, replies still owed: %0d",
               mirror.mismatches, mirror.expected_replies.size());
      $display("[single_wire_sensor_reader_unit] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("timeout waiting for the block");
    $display("[single_wire_sensor_reader_unit] ERROR");
    $finish;
  end

endmodule
